// ----- sv/ood_pkg.sv -----
//------------------------------------------------------------------------------
// ood_pkg
// Shared types and constants for the outline opcode decoder.
//------------------------------------------------------------------------------
package ood_pkg;

	localparam int COORD_WIDTH_DEF = 24;
	localparam int OUT_W           = 24;
	localparam logic [7:0] SCALE_RESET = 8'd15;

	// result kinds
	localparam logic [3:0] K_WIDTH = 4'd0;
	localparam logic [3:0] K_BOX   = 4'd1;
	localparam logic [3:0] K_MOVE  = 4'd2;
	localparam logic [3:0] K_LINE  = 4'd3;
	localparam logic [3:0] K_CURVE = 4'd4;
	localparam logic [3:0] K_SUB   = 4'd5;
	localparam logic [3:0] K_NAME  = 4'd6;
	localparam logic [3:0] K_CLOSE = 4'd7;
	localparam logic [3:0] K_BAD   = 4'd10;

	// opcodes
	localparam logic [3:0] OP_WIDTH   = 4'd0;
	localparam logic [3:0] OP_BOX     = 4'd1;
	localparam logic [3:0] OP_MOVE    = 4'd2;
	localparam logic [3:0] OP_LINE    = 4'd3;
	localparam logic [3:0] OP_CURVE   = 4'd4;
	localparam logic [3:0] OP_SUB     = 4'd5;
	localparam logic [3:0] OP_RDY     = 4'd6;
	localparam logic [3:0] OP_RDX     = 4'd7;
	localparam logic [3:0] OP_RBY     = 4'd8;
	localparam logic [3:0] OP_RBX     = 4'd9;
	localparam logic [3:0] OP_RBXY    = 4'd10;
	localparam logic [3:0] OP_SCURVE  = 4'd11;
	localparam logic [3:0] OP_BAD     = 4'd12;
	localparam logic [3:0] OP_CLOSE   = 4'd13;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_DIVWAIT,
		ST_OUT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic       take;      // accept input word into parser
		logic       exec;      // apply command to point, stage raw values
		logic       div_start; // start division of value div_idx
		logic [2:0] div_idx;
		logic       out_load;  // load output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic       done;      // accepted word finished a command
		logic       need_div;  // finished command has values to scale
		logic [2:0] nvals;     // number of values to scale
		logic       div_busy;
		logic       out_full;
	} sts_t;

	// operand bytes required per opcode
	function automatic logic [3:0] need_of(input logic [3:0] op);
		logic [3:0] n;
		case (op)
			4'd0:  n = 4'd2;
			4'd1:  n = 4'd8;
			4'd2:  n = 4'd4;
			4'd3:  n = 4'd4;
			4'd4:  n = 4'd12;
			4'd5:  n = 4'd9;
			4'd6:  n = 4'd2;
			4'd7:  n = 4'd2;
			4'd8:  n = 4'd1;
			4'd9:  n = 4'd1;
			4'd10: n = 4'd2;
			4'd11: n = 4'd6;
			default: n = 4'd0;
		endcase
		return n;
	endfunction

endpackage

// ----- sv/ood_div.sv -----
//------------------------------------------------------------------------------
// ood_div
// Iterative symmetric-rounding divider, one quotient bit per cycle.
//------------------------------------------------------------------------------
module ood_div #(
	parameter int CW = ood_pkg::COORD_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic signed [CW-1:0]   num,
	input  logic [7:0]             divisor,
	output logic                   busy,
	output logic                   done,
	output logic signed [ood_pkg::OUT_W-1:0] res
);
	import ood_pkg::*;

	localparam int CNTW = $clog2(CW + 2);
	// signed width wide enough for both the quotient and the output limits
	localparam int SW = (CW + 2 > OUT_W + 1) ? CW + 2 : OUT_W + 1;
	localparam logic signed [SW-1:0] OMAX = SW'((64'sd1 <<< (OUT_W-1)) - 1);
	localparam logic signed [SW-1:0] OMIN = -OMAX - 1;

	logic [CW:0]   rem_q;
	logic [CW:0]   quo_q;
	logic [CW:0]   num_q;
	logic [7:0]    d_q;
	logic          neg_q;
	logic [CNTW-1:0] cnt_q;
	logic          busy_q, done_q;
	logic [CW+1:0] trial;
	logic [CW:0]   mag;
	logic [7:0]    d_eff;
	logic signed [SW-1:0] sq;

	assign d_eff = (divisor == 8'd0) ? 8'd1 : divisor;
	assign mag   = num[CW-1] ? ({1'b0, ~num} + 1'b1) + {1'b0, {CW{1'b0}}}
	                         : {1'b0, num};
	assign trial = {rem_q, num_q[CW]} - {{(CW-6){1'b0}}, d_q};

	// restoring division of |v| + d/2 by d
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(CW + 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= mag + {{(CW-6){1'b0}}, d_eff[7:1]};
			d_q   <= d_eff;
			neg_q <= num[CW-1];
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[CW-1:0], 1'b0};
			if (!trial[CW+1]) begin
				rem_q <= trial[CW:0];
				quo_q <= {quo_q[CW-1:0], 1'b1};
			end else begin
				rem_q <= {rem_q[CW-1:0], num_q[CW]};
				quo_q <= {quo_q[CW-1:0], 1'b0};
			end
		end
	end

	// sign and saturation to output width
	always_comb begin
		sq = $signed(SW'({1'b0, quo_q}));
		if (neg_q) sq = -sq;
		if (sq > OMAX)
			res = OMAX[OUT_W-1:0];
		else if (sq < OMIN)
			res = OMIN[OUT_W-1:0];
		else
			res = sq[OUT_W-1:0];
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule

// ----- sv/ood_dp.sv -----
//------------------------------------------------------------------------------
// ood_dp
// Datapath: byte parser, operand store, current point, divider, result word.
//------------------------------------------------------------------------------
module ood_dp #(
	parameter int CW = ood_pkg::COORD_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ood_pkg::cmd_t          cmd,
	output ood_pkg::sts_t          sts,
	input  logic [7:0]             data_byte,
	input  logic [7:0]             scale,
	input  logic                   out_take,
	output logic [3:0]             kind,
	output logic signed [ood_pkg::OUT_W-1:0] val_a,
	output logic signed [ood_pkg::OUT_W-1:0] val_b,
	output logic signed [ood_pkg::OUT_W-1:0] val_c,
	output logic signed [ood_pkg::OUT_W-1:0] val_d,
	output logic signed [ood_pkg::OUT_W-1:0] val_e,
	output logic signed [ood_pkg::OUT_W-1:0] val_f,
	output logic                   glyph_end,
	output logic                   out_valid
);
	import ood_pkg::*;

	localparam logic signed [CW+1:0] PMAX = (CW+2)'((64'sd1 <<< (CW-1)) - 1);
	localparam logic signed [CW+1:0] PMIN = -PMAX - 1;

	logic [1:0]  phase_q;
	logic [3:0]  op_q;
	logic [3:0]  seen_q;
	logic [7:0]  hi_q;
	logic [15:0] words_q [6];
	logic signed [CW-1:0] px_q, py_q;
	logic [7:0]  left_q;

	// pending result held while values are scaled
	logic [3:0]  pk_q;
	logic        pg_q;
	logic [2:0]  pn_q;
	logic signed [CW-1:0] raw_q [6];
	logic signed [OUT_W-1:0] sc_q [6];
	logic [2:0]  didx_q;

	logic [3:0]  kind_q;
	logic signed [OUT_W-1:0] v_q [6];
	logic        ge_q, ov_q;

	logic        div_busy, div_done;
	logic signed [OUT_W-1:0] div_res;

	function automatic logic signed [CW-1:0] sat(input logic signed [CW+1:0] v);
		if (v > PMAX) return PMAX[CW-1:0];
		if (v < PMIN) return PMIN[CW-1:0];
		return v[CW-1:0];
	endfunction

	function automatic logic signed [CW+1:0] wv(input logic [15:0] w);
		return (CW+2)'($signed({1'b0, w}) - 18'sd32768);
	endfunction

	function automatic logic signed [CW+1:0] bv(input logic [15:0] w);
		return (CW+2)'($signed({1'b0, w[7:0]}) - 10'sd128);
	endfunction

	// parse step result, computed from the accepted byte
	logic        p_done, p_fin, p_div;
	logic [3:0]  p_kind;
	logic        p_ge;
	logic [2:0]  p_n;
	logic [7:0]  p_a;
	logic [3:0]  seen_nx;

	always_comb begin
		p_done = 1'b0;
		p_fin  = 1'b0;
		p_div  = 1'b0;
		p_kind = K_WIDTH;
		p_ge   = 1'b0;
		p_n    = 3'd0;
		p_a    = 8'd0;
		seen_nx = seen_q + 1'b1;
		if (phase_q == 2'd2) begin
			p_done = 1'b1;
			p_kind = K_NAME;
			p_a    = data_byte;
		end else if (phase_q != 2'd1) begin
			if (data_byte > 8'd15 || data_byte[3:0] == OP_BAD) begin
				p_done = 1'b1;
				p_kind = K_BAD;
				p_a    = data_byte;
			end else if (data_byte[3:0] >= OP_CLOSE) begin
				p_done = 1'b1;
				p_kind = data_byte[3:0] - 4'd6;
				p_ge   = (data_byte[3:0] != OP_CLOSE);
			end
		end else if (op_q == OP_SUB && seen_q >= 4'd8) begin
			p_done = 1'b1;
			p_div  = 1'b1;
			p_kind = K_SUB;
			p_n    = 3'd4;
		end else if (op_q != OP_SUB && seen_nx >= need_of(op_q)) begin
			p_done = 1'b1;
			p_fin  = 1'b1;
			p_div  = 1'b1;
		end
	end

	// parser state and operand store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 2'd0;
			op_q    <= 4'd0;
			seen_q  <= 4'd0;
			hi_q    <= 8'd0;
			left_q  <= 8'd0;
		end else if (cmd.take) begin
			if (phase_q == 2'd2) begin
				left_q <= left_q - 1'b1;
				if (left_q == 8'd1) phase_q <= 2'd0;
			end else if (phase_q != 2'd1) begin
				phase_q <= 2'd0;
				if (!(data_byte > 8'd15 || data_byte[3:0] >= OP_BAD)) begin
					op_q    <= data_byte[3:0];
					seen_q  <= 4'd0;
					phase_q <= 2'd1;
				end
			end else if (op_q == OP_SUB && seen_q >= 4'd8) begin
				left_q  <= data_byte;
				phase_q <= (data_byte != 8'd0) ? 2'd2 : 2'd0;
				seen_q  <= 4'd0;
			end else begin
				if (op_q <= OP_RDX && !seen_q[0]) hi_q <= data_byte;
				seen_q <= seen_nx;
				if (p_fin) begin
					phase_q <= 2'd0;
					seen_q  <= 4'd0;
				end
			end
		end
	end

	// operand words: written only, never cleared
	logic [2:0] widx;
	always_comb begin
		if (op_q <= OP_RDX) widx = (seen_q[3:1] >= 3'd6) ? seen_q[3:1] - 3'd6 : seen_q[3:1];
		else widx = (seen_q >= 4'd6) ? 3'(seen_q - 4'd6) : seen_q[2:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.take && phase_q == 2'd1 && !(op_q == OP_SUB && seen_q >= 4'd8)) begin
			if (op_q > OP_RDX) words_q[widx] <= {8'd0, data_byte};
			else if (seen_q[0]) words_q[widx] <= {hi_q, data_byte};
		end
	end

	// execute: point update and raw values (in the cycle after the finishing byte)
	logic signed [CW-1:0] nx, ny, ax, ay, bx, by;
	logic [3:0] ek;
	logic signed [CW-1:0] r [6];
	logic [2:0] en;

	always_comb begin
		nx = px_q;
		ny = py_q;
		ax = sat($signed({{2{px_q[CW-1]}}, px_q}) + bv(words_q[0]));
		ay = sat($signed({{2{py_q[CW-1]}}, py_q}) + bv(words_q[1]));
		bx = sat($signed({{2{px_q[CW-1]}}, px_q}) + bv(words_q[2]));
		by = sat($signed({{2{py_q[CW-1]}}, py_q}) + bv(words_q[3]));
		for (int i = 0; i < 6; i++) r[i] = '0;
		ek = K_LINE;
		en = 3'd2;
		case (op_q)
			OP_WIDTH: begin
				ek = K_WIDTH; en = 3'd1;
				r[0] = sat(wv(words_q[0]));
			end
			OP_BOX, OP_SUB: begin
				ek = (op_q == OP_SUB) ? K_SUB : K_BOX; en = 3'd4;
				for (int i = 0; i < 4; i++) r[i] = sat(wv(words_q[i]));
			end
			OP_MOVE, OP_LINE: begin
				ek = op_q;
				nx = sat(wv(words_q[0]));
				ny = sat(wv(words_q[1]));
			end
			OP_CURVE: begin
				ek = K_CURVE; en = 3'd6;
				for (int i = 0; i < 4; i++) r[i] = sat(wv(words_q[i]));
				nx = sat(wv(words_q[4]));
				ny = sat(wv(words_q[5]));
			end
			OP_SCURVE: begin
				ek = K_CURVE; en = 3'd6;
				r[0] = ax; r[1] = ay; r[2] = bx; r[3] = by;
				nx = sat($signed({{2{px_q[CW-1]}}, px_q}) + bv(words_q[4]));
				ny = sat($signed({{2{py_q[CW-1]}}, py_q}) + bv(words_q[5]));
			end
			OP_RDY: ny = sat($signed({{2{py_q[CW-1]}}, py_q}) + wv(words_q[0]));
			OP_RDX: nx = sat($signed({{2{px_q[CW-1]}}, px_q}) + wv(words_q[0]));
			OP_RBY: ny = sat($signed({{2{py_q[CW-1]}}, py_q}) + bv(words_q[0]));
			OP_RBX: nx = ax;
			default: begin
				nx = ax;
				ny = ay;
			end
		endcase
		if (op_q != OP_WIDTH && op_q != OP_BOX && op_q != OP_SUB) begin
			if (op_q == OP_CURVE || op_q == OP_SCURVE) begin
				r[4] = nx; r[5] = ny;
			end else begin
				r[0] = nx; r[1] = ny;
			end
		end
	end

	// pending result capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q <= '0;
			py_q <= '0;
			pn_q <= 3'd0;
		end else begin
			if (cmd.take && p_done) begin
				pk_q <= p_kind;
				pg_q <= p_ge;
				pn_q <= p_n;
				for (int i = 1; i < 6; i++) sc_q[i] <= '0;
				sc_q[0] <= OUT_W'(p_a);
			end
			if (cmd.exec) begin
				if (op_q != OP_WIDTH && op_q != OP_BOX && op_q != OP_SUB) begin
					px_q <= nx;
					py_q <= ny;
				end
				if (pk_q != K_SUB) begin
					pk_q <= ek;
					pn_q <= en;
				end
				for (int i = 0; i < 6; i++) raw_q[i] <= r[i];
			end
			if (div_done) sc_q[didx_q] <= div_res;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) didx_q <= cmd.div_idx;
	end

	ood_div #(.CW(CW)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.num     (raw_q[cmd.div_idx < 3'd6 ? cmd.div_idx : 3'd0]),
		.divisor (scale),
		.busy    (div_busy),
		.done    (div_done),
		.res     (div_res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else begin
			if (out_take) ov_q <= 1'b0;
			if (cmd.out_load) ov_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			kind_q <= pk_q;
			ge_q   <= pg_q;
			for (int i = 0; i < 6; i++) v_q[i] <= sc_q[i];
		end
	end

	assign sts.done     = p_done;
	assign sts.need_div = p_div;
	assign sts.nvals    = pn_q;
	assign sts.div_busy = div_busy;
	assign sts.out_full = ov_q;

	assign kind      = kind_q;
	assign glyph_end = ge_q;
	assign val_a     = v_q[0];
	assign val_b     = v_q[1];
	assign val_c     = v_q[2];
	assign val_d     = v_q[3];
	assign val_e     = v_q[4];
	assign val_f     = v_q[5];
	assign out_valid = ov_q;

endmodule

// ----- sv/ood_ctrl.sv -----
//------------------------------------------------------------------------------
// ood_ctrl
// Controller: accepts words, sequences scaling of each value, loads result.
//------------------------------------------------------------------------------
module ood_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  ood_pkg::sts_t  sts,
	output ood_pkg::cmd_t  cmd
);
	import ood_pkg::*;

	state_t     state_q, state_d;
	logic [2:0] idx_q;
	logic       div_q;
	logic       fin_q;

	// next state; every command that reaches EXEC has at least one value
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:    if (in_valid && sts.done) state_d = sts.need_div ? ST_EXEC : ST_OUT;
			ST_EXEC:    state_d = ST_DIV;
			ST_DIV:     state_d = ST_DIVWAIT;
			ST_DIVWAIT: if (!sts.div_busy && !div_q)
				state_d = (idx_q + 1'b1 == sts.nvals) ? ST_OUT : ST_DIV;
			ST_OUT:     if (!sts.out_full) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		in_stall = (state_q != ST_IDLE);
		cmd.take = (state_q == ST_IDLE) && in_valid;
		cmd.exec = (state_q == ST_EXEC) && fin_q;
		cmd.div_start = (state_q == ST_DIV);
		cmd.div_idx = idx_q;
		cmd.out_load = (state_q == ST_OUT) && !sts.out_full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= 3'd0;
			div_q   <= 1'b0;
			fin_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			div_q   <= (state_q == ST_DIV);
			if (state_q == ST_IDLE) begin
				idx_q <= 3'd0;
				fin_q <= 1'b1;
			end
			if (state_q == ST_DIVWAIT && !sts.div_busy && !div_q)
				idx_q <= idx_q + 1'b1;
		end
	end

	// no word taken while the controller is busy
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !cmd.take)
		else $error("word taken while busy");

	// a division start is followed by the divider being busy
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> sts.div_busy)
		else $error("divider did not start");

	// result loaded only into an empty output register
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !sts.out_full)
		else $error("output overwritten");

endmodule

// ----- sv/outline_opcode_decoder.sv -----
//------------------------------------------------------------------------------
// outline_opcode_decoder
// Glyph outline byte parser with scaled coordinate results.
//------------------------------------------------------------------------------
// Sequence: a byte that finishes no command is just taken. A finished
// command scales N values (0..6), each in turn through one shared
// bit-serial divider, and then loads the result register.
// Throughput: one byte at a time; the divider loop sets the rate.
// Reset (arst_n low): parser idle, point at origin, scale 15, no result held.
module outline_opcode_decoder #(
	parameter int COORD_WIDTH = ood_pkg::COORD_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  scale_divisor,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  kind,
	output logic signed [ood_pkg::OUT_W-1:0] val_a,
	output logic signed [ood_pkg::OUT_W-1:0] val_b,
	output logic signed [ood_pkg::OUT_W-1:0] val_c,
	output logic signed [ood_pkg::OUT_W-1:0] val_d,
	output logic signed [ood_pkg::OUT_W-1:0] val_e,
	output logic signed [ood_pkg::OUT_W-1:0] val_f,
	output logic        glyph_end
);
	import ood_pkg::*;

	logic [7:0] scale_q;
	cmd_t cmd;
	sts_t sts;

	// scale register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) scale_q <= SCALE_RESET;
		else if (cfg_valid) scale_q <= scale_divisor;
	end
	assign cfg_ready = 1'b1;

	ood_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	ood_dp #(.CW(COORD_WIDTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.data_byte (data_byte),
		.scale     (scale_q),
		.out_take  (out_valid && !out_stall),
		.kind      (kind),
		.val_a     (val_a),
		.val_b     (val_b),
		.val_c     (val_c),
		.val_d     (val_d),
		.val_e     (val_e),
		.val_f     (val_f),
		.glyph_end (glyph_end),
		.out_valid (out_valid)
	);

endmodule
